@@ hw/rtl/cal_pkg.sv @@
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants for the cursor array list
// Command and response item layouts, opcodes and store geometry.
// ----------------------------------------------------------------------------
package cal_pkg;

  // Store geometry
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 6;
  localparam int WORD_W = 32;

  // Capacity register reset value
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(32);

  // Opcodes
  localparam logic [3:0] OP_BEGIN      = 4'd0;
  localparam logic [3:0] OP_END        = 4'd1;
  localparam logic [3:0] OP_NEXT       = 4'd2;
  localparam logic [3:0] OP_PRIOR      = 4'd3;
  localparam logic [3:0] OP_INS_AFTER  = 4'd4;
  localparam logic [3:0] OP_INS_BEFORE = 4'd5;
  localparam logic [3:0] OP_REMOVE     = 4'd6;
  localparam logic [3:0] OP_REPLACE    = 4'd7;
  localparam logic [3:0] OP_READ       = 4'd8;
  localparam logic [3:0] OP_CLEAR      = 4'd9;

  // Command item
  typedef struct packed {
    logic [3:0]               op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // Response item
  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]         item_count;
    logic [4:0]               cursor_pos;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

  // Store write port
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [WORD_W-1:0] data;
  } cal_wr_t;

endpackage

@@ hw/rtl/cal_store.sv @@
// ----------------------------------------------------------------------------
// cal_store: entry store of the cursor array list
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module cal_store
  import cal_pkg::*;
(
  input  logic                     clk,
  input  cal_wr_t                  wr,
  input  logic [IDX_W-1:0]         raddr,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cursor_array_list_core.sv @@
// ----------------------------------------------------------------------------
// cursor_array_list_core: ordered list of signed words with a cursor
// Commands move the cursor, insert, remove, replace, read or clear; inserts
// and removes shift entries through the store one per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | cmd_t (op, value)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_t (ok ... is_full)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data (list_capacity)
//
//  Cursor moves, replace and clear go straight to the response; read first waits
//  for the store read data. Insert and remove move n entries
//  (count - slot, last - cursor), one per cycle via the read port.
//  One command is in work at a time; the next is taken once the response
//  sits in the output register, even if rsp_ready is low.
//  Reset (synchronous) empties the list and sets capacity to 32.
// ----------------------------------------------------------------------------
module cursor_array_list_core
  import cal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_WR_VAL,
    S_DONE
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         cursor;
  logic [CNT_W-1:0]         capacity;
  logic [IDX_W-1:0]         src;
  logic [IDX_W-1:0]         pend_src;
  logic                     pend;
  logic [CNT_W-1:0]         left;
  logic                     up;
  logic                     shift_after;
  logic signed [WORD_W-1:0] val;
  logic                     res_ok;
  logic signed [WORD_W-1:0] res_rd;

  cal_wr_t                  wr;
  logic [IDX_W-1:0]         raddr;
  logic signed [WORD_W-1:0] rdata;

  logic                     fire;
  logic                     empty;
  logic                     full;
  logic [CNT_W-1:0]         eff_cap;
  logic [IDX_W-1:0]         last;
  logic [IDX_W-1:0]         slot;
  logic                     out_free;

  cal_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Capacity clamped to 1..DEPTH
  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (capacity > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end
  end

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign fire      = cmd_valid && cmd_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // List status before the command
  assign empty = (count == '0);
  assign full  = (count >= eff_cap);
  assign last  = empty ? '0 : IDX_W'(count - CNT_W'(1));
  assign slot  = empty ? '0 :
                 (cmd.op == OP_INS_AFTER) ? IDX_W'(cursor + IDX_W'(1)) : cursor;

  // Store read address: cursor on accept, shift source while shifting
  always_comb begin
    raddr = cursor;
    if (state == S_SHIFT) begin
      raddr = src;
    end
  end

  // Store write port: replace, shift moves, and the new word of an insert
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = cursor;
    wr.data = cmd.value;
    case (state)
      S_IDLE: begin
        wr.en = fire && (cmd.op == OP_REPLACE) && !empty;
      end
      S_SHIFT: begin
        wr.en   = pend;
        wr.addr = up ? IDX_W'(pend_src + IDX_W'(1)) : IDX_W'(pend_src - IDX_W'(1));
        wr.data = rdata;
      end
      S_WR_VAL: begin
        wr.en   = 1'b1;
        wr.data = val;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      capacity  <= CAP_RESET;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // a response loaded in S_DONE sets valid instead
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (fire) begin
            res_ok      <= 1'b0;
            res_rd      <= '0;
            val         <= cmd.value;
            pend        <= 1'b0;
            shift_after <= 1'b0;
            state       <= S_DONE;
            case (cmd.op)
              OP_BEGIN: begin
                if (!empty) begin
                  cursor <= '0;
                  res_ok <= 1'b1;
                end
              end
              OP_END, OP_NEXT: begin
                if (!empty && cursor != last) begin
                  cursor <= (cmd.op == OP_END) ? last : IDX_W'(cursor + IDX_W'(1));
                  res_ok <= 1'b1;
                end
              end
              OP_PRIOR: begin
                if (!empty && cursor != '0) begin
                  cursor <= IDX_W'(cursor - IDX_W'(1));
                  res_ok <= 1'b1;
                end
              end
              OP_INS_AFTER, OP_INS_BEFORE: begin
                if (!full) begin
                  res_ok <= 1'b1;
                  count  <= CNT_W'(count + CNT_W'(1));
                  cursor <= slot;
                  src    <= IDX_W'(count - CNT_W'(1));
                  left   <= CNT_W'(count - CNT_W'(slot));
                  up     <= 1'b1;
                  state  <= S_SHIFT;
                end
              end
              OP_REMOVE: begin
                if (!empty) begin
                  res_ok      <= 1'b1;
                  count       <= CNT_W'(count - CNT_W'(1));
                  src         <= IDX_W'(cursor + IDX_W'(1));
                  left        <= CNT_W'(last - cursor);
                  up          <= 1'b0;
                  shift_after <= 1'b1;
                  state       <= S_RD_WAIT;
                  if (cursor == last) begin
                    cursor <= (cursor == '0) ? '0 : IDX_W'(cursor - IDX_W'(1));
                  end
                end
              end
              OP_REPLACE: begin
                res_ok <= !empty;
              end
              OP_READ: begin
                if (!empty) begin
                  res_ok <= 1'b1;
                  state  <= S_RD_WAIT;
                end
              end
              OP_CLEAR: begin
                if (!empty) begin
                  count  <= '0;
                  cursor <= '0;
                  res_ok <= 1'b1;
                end
              end
              default: begin
                res_ok <= 1'b0;
              end
            endcase
          end
        end

        // Word at the cursor arrives from the store
        S_RD_WAIT: begin
          res_rd <= rdata;
          state  <= shift_after ? S_SHIFT : S_DONE;
        end

        // One entry moved per cycle: read source, write it one place over
        S_SHIFT: begin
          if (left != '0) begin
            src      <= up ? IDX_W'(src - IDX_W'(1)) : IDX_W'(src + IDX_W'(1));
            left     <= CNT_W'(left - CNT_W'(1));
            pend     <= 1'b1;
            pend_src <= src;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= up ? S_WR_VAL : S_DONE;
            end
          end
        end

        // New word lands in the opened gap
        S_WR_VAL: begin
          state <= S_DONE;
        end

        // Hand the response to the output register
        S_DONE: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            rsp.ok         <= res_ok;
            rsp.read_value <= res_rd;
            rsp.item_count <= count;
            rsp.cursor_pos <= 5'(cursor);
            rsp.is_empty   <= (count == '0);
            rsp.is_full    <= (count >= eff_cap);
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/cursor_list_checker.sv @@
// ----------------------------------------------------------------------------
// cursor_list_checker: response checker for the cursor array list
// Watches the command, response and capacity channels, keeps its own copy
// of the list, cursor and capacity, predicts one response per command and
// compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cursor_list_checker
  import cal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic             cmd_ready,
  input  cmd_t             cmd,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               mismatches,
  output int               open_answers,
  output int               answered
);

  // Shadow list state
  logic signed [WORD_W-1:0] list_words [DEPTH];
  logic [CNT_W-1:0]         word_count;
  logic [4:0]               cursor_at;
  logic [CNT_W-1:0]         capacity_reg;

  // Predicted responses, oldest first
  rsp_t pending_answers [$];

  initial begin
    mismatches = 0;
    answered = 0;
    open_answers = 0;
  end

  // One line per problem; printing is capped, counting is not
  task automatic log_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Effective capacity: register clamped to 1..DEPTH
  function automatic int usable_capacity();
    int c;
    c = int'(capacity_reg);
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Apply one command to the shadow list and return the response it earns
  function automatic rsp_t apply_list_command(cmd_t c);
    rsp_t r;
    int   last;
    int   slot;
    int   i;
    logic empty;
    logic full;
    r = '0;
    empty = (word_count == '0);
    full = (int'(word_count) >= usable_capacity());
    last = empty ? 0 : int'(word_count) - 1;
    case (c.op)
      OP_BEGIN: begin
        if (!empty) begin
          cursor_at = '0;
          r.ok = 1'b1;
        end
      end
      OP_END, OP_NEXT: begin
        if (!empty && int'(cursor_at) != last) begin
          cursor_at = (c.op == OP_END) ? 5'(last) : cursor_at + 5'd1;
          r.ok = 1'b1;
        end
      end
      OP_PRIOR: begin
        if (!empty && cursor_at != '0) begin
          cursor_at = cursor_at - 5'd1;
          r.ok = 1'b1;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (!full) begin
          if (empty) begin
            cursor_at = '0;
            list_words[0] = c.value;
          end else begin
            slot = (c.op == OP_INS_AFTER) ? int'(cursor_at) + 1 : int'(cursor_at);
            // open the gap from the top down
            for (i = int'(word_count); i > slot; i--) list_words[i] = list_words[i-1];
            list_words[slot] = c.value;
            cursor_at = 5'(slot);
          end
          word_count = word_count + 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!empty) begin
          r.read_value = list_words[cursor_at];
          if (int'(cursor_at) == last) begin
            // removing the tail steps the cursor back
            if (cursor_at != '0) cursor_at = cursor_at - 5'd1;
          end else begin
            for (i = int'(cursor_at); i < last; i++) list_words[i] = list_words[i+1];
          end
          word_count = word_count - 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (!empty) begin
          list_words[cursor_at] = c.value;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (!empty) begin
          r.read_value = list_words[cursor_at];
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (!empty) begin
          word_count = '0;
          cursor_at = '0;
          r.ok = 1'b1;
        end
      end
      default: ;  // unused opcodes are refused
    endcase
    r.item_count = word_count;
    r.cursor_pos = cursor_at;
    r.is_empty = (word_count == '0);
    r.is_full = (int'(word_count) >= usable_capacity());
    return r;
  endfunction

  // Field-by-field comparison of one response
  task automatic compare_answer(input rsp_t got, input rsp_t want);
    if (got.ok !== want.ok)
      log_mismatch($sformatf("rsp %0d ok got %b exp %b", answered, got.ok, want.ok));
    if (got.read_value !== want.read_value)
      log_mismatch($sformatf("rsp %0d read_value got %h exp %h", answered,
                             got.read_value, want.read_value));
    if (got.item_count !== want.item_count)
      log_mismatch($sformatf("rsp %0d item_count got %0d exp %0d", answered,
                             got.item_count, want.item_count));
    if (got.cursor_pos !== want.cursor_pos)
      log_mismatch($sformatf("rsp %0d cursor_pos got %0d exp %0d", answered,
                             got.cursor_pos, want.cursor_pos));
    if (got.is_empty !== want.is_empty)
      log_mismatch($sformatf("rsp %0d is_empty got %b exp %b", answered,
                             got.is_empty, want.is_empty));
    if (got.is_full !== want.is_full)
      log_mismatch($sformatf("rsp %0d is_full got %b exp %b", answered,
                             got.is_full, want.is_full));
  endtask

  // Channel monitor: retire responses first, then take in new commands
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      word_count = '0;
      cursor_at = '0;
      capacity_reg = CAP_RESET;
      pending_answers.delete();
    end else begin
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
        if (pending_answers.size() == 0) begin
          log_mismatch($sformatf("response with no command outstanding, ok %b", rsp.ok));
        end else begin
          want = pending_answers.pop_front();
          compare_answer(rsp, want);
        end
        answered++;
      end
      if (cfg_valid && cfg_ready === 1'b1) capacity_reg = cfg_data;
      if (cmd_valid && cmd_ready === 1'b1) pending_answers.push_back(apply_list_command(cmd));
    end
    open_answers <= pending_answers.size();
  end

endmodule

@@ tb/tb_cursor_array_list_core.sv @@
// ----------------------------------------------------------------------------
// tb_cursor_array_list_core: testbench top for the cursor array list
// Drives list commands and capacity writes: a directed pass over empty,
// full and edge-of-list cases, then random command mixes under changing
// capacity and idle patterns, including a long response stall.
// ----------------------------------------------------------------------------
module tb_cursor_array_list_core;
  import cal_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_CYCLES = 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_t             cmd = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  int mismatches;
  int open_answers;
  int answered;

  // Idle rates in percent and long-stall control
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic stall_req = 1'b0;
  logic stall_done = 1'b0;
  int   hold_left = 0;

  int cycle_count = 0;
  int cmds_sent = 0;
  int cap_writes = 0;

  cursor_array_list_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cursor_list_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .open_answers (open_answers),
    .answered     (answered)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req && !stall_done) begin
      rsp_ready <= 1'b0;
      hold_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one command; valid stays high after acceptance so that a
  // back-to-back item needs no drop in between
  task automatic send_cmd(input logic [3:0] op, input logic [WORD_W-1:0] val);
    cmd_t c;
    c.op = op;
    c.value = val;
    if ($urandom_range(99) < snd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    cmds_sent++;
  endtask

  // Stop offering and wait until every response is back
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (open_answers != 0);
  endtask

  // Capacity write; only called with the list idle
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Random command mix: inserts outweigh removes so the list fills up,
  // with occasional clears and unused opcodes
  task automatic random_burst(input int n);
    int               pick;
    logic [3:0]       op;
    logic [WORD_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30)      op = pick[0] ? OP_INS_AFTER : OP_INS_BEFORE;
      else if (pick < 40) op = OP_NEXT;
      else if (pick < 46) op = OP_PRIOR;
      else if (pick < 49) op = OP_BEGIN;
      else if (pick < 52) op = OP_END;
      else if (pick < 66) op = OP_REMOVE;
      else if (pick < 74) op = OP_REPLACE;
      else if (pick < 96) op = OP_READ;
      else if (pick < 97) op = OP_CLEAR;
      else                op = 4'($urandom_range(15, 10));
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
        default: val = $urandom;
      endcase
      send_cmd(op, val);
    end
  endtask

  // Stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command on an empty list is refused
    write_capacity(6'd3);
    send_cmd(OP_BEGIN, 32'h0);
    send_cmd(OP_END, 32'h0);
    send_cmd(OP_NEXT, 32'h0);
    send_cmd(OP_PRIOR, 32'h0);
    send_cmd(OP_REMOVE, 32'h0);
    send_cmd(OP_REPLACE, 32'h1234_5678);
    send_cmd(OP_READ, 32'h0);
    send_cmd(OP_CLEAR, 32'h0);
    // fill to capacity with extreme words, then one insert too many
    send_cmd(OP_INS_BEFORE, 32'h8000_0000);
    send_cmd(OP_INS_AFTER, 32'h7fff_ffff);
    send_cmd(OP_INS_BEFORE, 32'hffff_ffff);
    send_cmd(OP_INS_AFTER, 32'h0);
    // cursor at the ends of the list
    send_cmd(OP_NEXT, 32'h0);
    send_cmd(OP_NEXT, 32'h0);
    send_cmd(OP_END, 32'h0);
    send_cmd(OP_BEGIN, 32'h0);
    send_cmd(OP_PRIOR, 32'h0);
    send_cmd(OP_REPLACE, 32'h5555_aaaa);
    send_cmd(4'd15, 32'hffff_ffff);
    send_cmd(OP_REMOVE, 32'h0);
    // capacity lowered below the count, then zero, then past the store size
    drain();
    write_capacity(6'd1);
    send_cmd(OP_INS_AFTER, 32'h0bad_cafe);
    drain();
    write_capacity(6'd0);
    send_cmd(OP_END, 32'h0);
    drain();
    write_capacity(6'd63);
    send_cmd(OP_INS_BEFORE, 32'h1357_9bdf);
    send_cmd(OP_END, 32'h0);
    send_cmd(OP_REMOVE, 32'h0);
    send_cmd(OP_CLEAR, 32'h0);

    // Random, sender mostly busy, receiver mostly idle
    drain();
    snd_idle_pct <= 6;
    rcv_idle_pct <= 81;
    write_capacity(6'd32);
    random_burst(100);
    drain();
    write_capacity(6'($urandom_range(9, 2)));
    random_burst(100);

    // Random, sender mostly idle, receiver mostly ready
    drain();
    snd_idle_pct <= 81;
    rcv_idle_pct <= 6;
    write_capacity(6'd0);
    random_burst(60);
    drain();
    write_capacity(6'($urandom_range(63)));
    random_burst(140);

    // Random, no idling, with one long response stall to back up the input
    drain();
    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    write_capacity(6'd63);
    stall_req <= 1'b1;
    random_burst(100);
    drain();
    write_capacity(6'($urandom_range(31, 10)));
    random_burst(100);

    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d commands and %0d responses under %0d capacity writes,",
             cmds_sent, answered, cap_writes);
    $display("with empty and full lists, cursor at both ends, bad opcodes and a long stall.");
    if (mismatches == 0 && open_answers == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cal_pkg.sv
hw/rtl/cal_store.sv
hw/rtl/cursor_array_list_core.sv
tb/cursor_list_checker.sv
tb/tb_cursor_array_list_core.sv
